### hw/rtl/assert_macros.svh
// Assertion macros shared by the gray pixel unit RTL.
// Each macro builds one labeled concurrent assertion clocked on i_clk, reset on i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every edge outside reset.
`define PG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that implies a result in the following cycle.
`define PG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/pgray_pkg.sv
// Shared types and constants of the palette/RGB to gray pixel unit.
// No dependencies; imported by pgray_cfg, pgray_luma and the top level.
package pgray_pkg;

    // Gray table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam logic [8:0] TBL_LIMIT = 9'(TABLE_DEPTH);

    // BT.601 luma weights, 16 fractional bits
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    // Palette sizes with special handling
    localparam logic [8:0] PAL_TWO     = 9'd2;
    localparam logic [8:0] PAL_SIXTEEN = 9'd16;
    localparam logic [8:0] PAL_RESET   = 9'd256;

    // Item opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    // Pixel modes
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_RGB     = 2'd1;
    localparam logic [1:0] MODE_DIRECT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RULES = 2'd0;
    localparam logic [1:0] CFG_MODE  = 2'd1;
    localparam logic [1:0] CFG_SIZE  = 2'd2;

    // Container rules
    localparam logic RULES_PNG = 1'b0;
    localparam logic RULES_BMP = 1'b1;

    typedef struct packed {
        logic       rules;
        logic [1:0] mode;
        logic [8:0] size;
    } t_cfg;

endpackage

### hw/rtl/pgray_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module pgray_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pgray_luma.sv
// Fixed-point BT.601 luma of one RGB triple: (19595R + 38470G + 7471B) >> 16.
// Depends on pgray_pkg for the weights.
module pgray_luma
    import pgray_pkg::*;
(
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma
);

    logic [23:0] w_prod_r;
    logic [23:0] w_prod_g;
    logic [23:0] w_prod_b;
    logic [23:0] w_sum;

    // Weighted sum; weights add to 65536, so the sum fits 24 bits
    assign w_prod_r = 24'(i_red)   * 24'(LUMA_R);
    assign w_prod_g = 24'(i_green) * 24'(LUMA_G);
    assign w_prod_b = 24'(i_blue)  * 24'(LUMA_B);
    assign w_sum    = w_prod_r + w_prod_g + w_prod_b;

    // Drop the fraction
    assign o_luma = w_sum[23:16];

endmodule

### hw/rtl/pgray_cfg.sv
// Configuration registers of the gray pixel unit, written over a valid/ready port.
// Depends on pgray_pkg for register indexes and the t_cfg struct.
module pgray_cfg
    import pgray_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode one write word; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RULES: n_cfg.rules = i_cfg_data[0];
                CFG_MODE:  n_cfg.mode  = i_cfg_data[1:0];
                CFG_SIZE:  n_cfg.size  = i_cfg_data;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rules <= RULES_PNG;
            r_cfg.mode  <= MODE_PALETTE;
            r_cfg.size  <= PAL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

### hw/rtl/palette_rgb_to_gray_pixel_unit.sv
// Top level of the palette/RGB to gray pixel unit.
// Depends on pgray_pkg, pgray_cfg, pgray_luma, pgray_ram and assert_macros.svh.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+---------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_opcode i_entry_index i_pixel_code i_red/green/blue
//  out     | o_out_valid  | i_out_ready  | o_gray_out
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index i_cfg_data
//
// One word per cycle unless output stalls; pixel words pass stage 1, then the output register.
// The gray table RAM is written and read in the accept cycle; its registered read sets
// the extra stage. Begin and load words give no output word.
// Reset clears the table through one valid bit per entry; there is no clearing pass.
// A stalled output holds one word and the decode stage holds a second before input stalls.
module palette_rgb_to_gray_pixel_unit
    import pgray_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_pixel_code,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_gray_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    `include "assert_macros.svh"

    t_cfg w_cfg;

    // Stage 1 and output registers
    logic                   r_s1_vld;
    logic                   r_s1_use_ram;
    logic [7:0]             r_s1_val;
    logic                   r_out_vld;
    logic [7:0]             r_out_gray;
    logic                   r_all_gray;
    logic [TABLE_DEPTH-1:0] r_tbl_vld;

    logic              n_s1_use_ram;
    logic [7:0]        n_s1_val;
    logic [7:0]        n_out_gray;

    logic              w_out_free;
    logic              w_s1_move;
    logic              w_accept;
    logic              w_acc_load;
    logic              w_acc_pixel;
    logic              w_load_in;
    logic              w_pix_in;
    logic              w_entry_gray;
    logic              w_two_case;
    logic              w_step_case;
    logic [7:0]        w_luma;
    logic [7:0]        w_ram_q;
    logic [TBL_AW-1:0] w_waddr;
    logic [TBL_AW-1:0] w_raddr;

    pgray_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pgray_luma u_luma (
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_luma  (w_luma)
    );

    // Handshake: stage 1 moves when the output register is free
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_s1_move   = r_s1_vld && w_out_free;
    assign o_in_ready  = !r_s1_vld || w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_acc_load  = w_accept && (i_opcode == OP_LOAD);
    assign w_acc_pixel = w_accept && (i_opcode == OP_PIXEL);

    // Table addressing; slots beyond the depth are out of the table
    assign w_load_in = ({1'b0, i_entry_index} < TBL_LIMIT);
    assign w_pix_in  = ({1'b0, i_pixel_code} < TBL_LIMIT);
    assign w_waddr   = i_entry_index[TBL_AW-1:0];
    assign w_raddr   = i_pixel_code[TBL_AW-1:0];

    pgray_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_acc_load && w_load_in),
        .i_waddr (w_waddr),
        .i_wdata (w_luma),
        .i_re    (w_acc_pixel),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Palette special cases: BMP two-entry and non-gray sixteen-entry give 16*index
    assign w_entry_gray = (i_red == i_green) && (i_red == i_blue);
    assign w_two_case   = (w_cfg.rules == RULES_BMP) && (w_cfg.size == PAL_TWO)
                          && (i_pixel_code < 8'd2);
    assign w_step_case  = (w_cfg.size == PAL_SIXTEEN) && !r_all_gray
                          && (i_pixel_code < 8'd16);

    // Decode a pixel word into a ready value or a table read
    always_comb begin
        n_s1_use_ram = 1'b0;
        n_s1_val     = i_pixel_code;
        case (w_cfg.mode)
            MODE_PALETTE: begin
                if (w_two_case || w_step_case) begin
                    n_s1_val = {i_pixel_code[3:0], 4'b0000};
                end else if (w_pix_in && r_tbl_vld[w_raddr]) begin
                    n_s1_use_ram = 1'b1;
                end else begin
                    n_s1_val = 8'd0;
                end
            end
            MODE_RGB: n_s1_val = w_luma;
            default:  n_s1_val = i_pixel_code;
        endcase
    end

    // Hold the all-gray flag and table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_gray <= 1'b1;
            r_tbl_vld  <= '0;
        end else begin
            if (w_accept && (i_opcode == OP_BEGIN)) begin
                r_all_gray <= 1'b1;
            end else if (w_acc_load && !w_entry_gray) begin
                r_all_gray <= 1'b0;
            end
            if (w_acc_load && w_load_in) begin
                r_tbl_vld[w_waddr] <= 1'b1;
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= w_acc_pixel;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_acc_pixel) begin
            r_s1_use_ram <= n_s1_use_ram;
            r_s1_val     <= n_s1_val;
        end
    end

    // Select table data or the decoded value
    assign n_out_gray = r_s1_use_ram ? w_ram_q : r_s1_val;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_gray <= n_out_gray;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_gray_out  = r_out_gray;

    // Checks
    `PG_ASSERT_ALWAYS(a_stall_full, o_in_ready || (r_s1_vld && r_out_vld), "input stalled with room")
    `PG_ASSERT_NEXT(a_begin_rearm, w_accept && (i_opcode == OP_BEGIN), r_all_gray, "begin did not rearm flag")
    `PG_ASSERT_NEXT(a_color_clear, w_acc_load && !w_entry_gray, !r_all_gray, "colored entry kept flag")
    `PG_ASSERT_NEXT(a_load_valid, w_acc_load && w_load_in, r_tbl_vld[$past(w_waddr)], "load left entry invalid")

endmodule
